/* design/atbp_pkg.sv */
// Shared constants, codes and control types of the arrival tree barrier pool.
package atbp_pkg;

  localparam int ACTION_W = 2;
  localparam int TREE_W   = 6;
  localparam int LEAF_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;

  localparam int DEF_NUM_TREES  = 64;
  localparam int DEF_MAX_LEAVES = 32;

  localparam logic [CFG_W-1:0] LEAVES_RST = 6'd32;

  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ARRIVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic commit;
    logic clr_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

/* design/atbp_in_if.sv */
// Request channel interface of the arrival tree barrier pool.
interface atbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [atbp_pkg::ACTION_W-1:0] action;
  logic [atbp_pkg::TREE_W-1:0]   tree_id;
  logic [atbp_pkg::LEAF_W-1:0]   leaf_index;

  modport source (output valid, output action, output tree_id, output leaf_index,
                  input ready);
  modport sink   (input valid, input action, input tree_id, input leaf_index,
                  output ready);
endinterface

/* design/atbp_out_if.sv */
// Result channel interface of the arrival tree barrier pool.
interface atbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [atbp_pkg::STATUS_W-1:0] status;
  logic [atbp_pkg::TREE_W-1:0]   granted_tree;
  logic                          is_last;

  modport source (output valid, output status, output granted_tree, output is_last,
                  input ready);
  modport sink   (input valid, input status, input granted_tree, input is_last,
                  output ready);
endinterface

/* design/atbp_cfg_if.sv */
// Configuration write channel interface of the arrival tree barrier pool.
interface atbp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [atbp_pkg::CFG_W-1:0] leaves_in_use;

  modport source (output valid, output leaves_in_use, input ready);
  modport sink   (input valid, input leaves_in_use, output ready);
endinterface

/* design/atbp_ctrl.sv */
// Controller state machine: memory clearing sweep, request sequencing, output valid.
module atbp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output atbp_pkg::ctrl_cmd_t   cmd,
  input  atbp_pkg::dp_status_t  dp_stat
);
  import atbp_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (dp_stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/atbp_dp.sv */
// Datapath: free list head, link and flag memories, arrival walk and result registers.
module atbp_dp #(
  parameter int NUM_TREES  = atbp_pkg::DEF_NUM_TREES,
  parameter int MAX_LEAVES = atbp_pkg::DEF_MAX_LEAVES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  atbp_pkg::ctrl_cmd_t           cmd,
  output atbp_pkg::dp_status_t          dp_stat,
  input  logic [atbp_pkg::ACTION_W-1:0] in_action,
  input  logic [atbp_pkg::TREE_W-1:0]   in_tree_id,
  input  logic [atbp_pkg::LEAF_W-1:0]   in_leaf_index,
  input  logic                          cfg_we,
  input  logic [atbp_pkg::CFG_W-1:0]    cfg_leaves,
  output logic [atbp_pkg::STATUS_W-1:0] out_status,
  output logic [atbp_pkg::TREE_W-1:0]   out_granted_tree,
  output logic                          out_is_last
);
  import atbp_pkg::*;

  localparam int TW  = $clog2(NUM_TREES);
  localparam int LKW = TW + 1;
  localparam int FW  = MAX_LEAVES - 1;
  localparam int CW  = $clog2(MAX_LEAVES) + 1;
  localparam int NLV = $clog2(MAX_LEAVES);

  // Link entries hold an empty mark above the tree id.
  logic [LKW-1:0] link_mem [NUM_TREES];
  logic [FW-1:0]  flag_mem [NUM_TREES];

  logic [ACTION_W-1:0] op_action_r;
  logic [TREE_W-1:0]   op_tree_r;
  logic [LEAF_W-1:0]   op_leaf_r;
  logic [CFG_W-1:0]    leaves_r;
  logic                head_empty_r, head_empty_nxt;
  logic [TW-1:0]       head_id_r, head_id_nxt;
  logic [TW-1:0]       clr_addr_r;
  logic [LKW-1:0]      link_rd_r;
  logic [FW-1:0]       flags_rd_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [TREE_W-1:0]   granted_r, granted_nxt;
  logic                last_r, last_nxt;

  logic [31:0]    in_tree32, tree32, head32, leaves32, eff32, p1_32;
  logic [TW-1:0]  in_tree_addr, tree_addr, wr_addr;
  logic           tree_ok, leaf_ok, clr_last;
  logic [CW-1:0]  p1, hop;
  logic [FW-1:0]  probe, set_mask;
  logic           found;
  logic           link_we, flag_we;
  logic [LKW-1:0] link_wdata;
  logic [FW-1:0]  flag_wdata;

  assign in_tree32    = 32'(in_tree_id);
  assign in_tree_addr = in_tree32[TW-1:0];
  assign tree32       = 32'(op_tree_r);
  assign tree_addr    = tree32[TW-1:0];
  assign tree_ok      = tree32 < 32'(NUM_TREES);
  assign head32       = 32'(head_id_r);
  assign clr_last     = (clr_addr_r == TW'(NUM_TREES - 1));
  assign dp_stat.clr_last = clr_last;

  // Leaf count clamped to the range the tree supports.
  assign leaves32 = 32'(leaves_r);
  always_comb begin
    if (leaves32 < 32'd2) begin
      eff32 = 32'd2;
    end else if (leaves32 > 32'(MAX_LEAVES)) begin
      eff32 = 32'(MAX_LEAVES);
    end else begin
      eff32 = leaves32;
    end
  end

  assign leaf_ok = 32'(op_leaf_r) < eff32;
  // Heap position plus one; ancestor k of the leaf is (p1 >> k) - 1.
  assign p1_32   = eff32 + 32'(op_leaf_r);
  assign p1      = p1_32[CW-1:0];

  // Find the nearest ancestor whose visited flag is still clear.
  always_comb begin
    found    = 1'b0;
    set_mask = '0;
    probe    = '0;
    hop      = '0;
    for (int k = 1; k <= NLV; k++) begin
      hop = p1 >> k;
      if (!found && hop != '0) begin
        for (int j = 0; j < FW; j++) begin
          probe[j] = ((hop - CW'(1)) == CW'(j));
        end
        if ((flags_rd_r & probe) == '0) begin
          found    = 1'b1;
          set_mask = probe;
        end
      end
    end
  end

  always_comb begin
    status_nxt     = ST_OK;
    granted_nxt    = '0;
    last_nxt       = 1'b0;
    head_empty_nxt = head_empty_r;
    head_id_nxt    = head_id_r;
    link_we        = 1'b0;
    flag_we        = 1'b0;
    link_wdata     = {head_empty_r, head_id_r};
    flag_wdata     = '0;
    wr_addr        = tree_addr;

    if (cmd.clr_step) begin
      wr_addr    = clr_addr_r;
      link_we    = 1'b1;
      flag_we    = 1'b1;
      link_wdata = clr_last ? {1'b1, {TW{1'b0}}} : {1'b0, TW'(clr_addr_r + TW'(1))};
    end else if (cmd.commit) begin
      case (op_action_r)
        ACT_ALLOC: begin
          if (!head_empty_r) begin
            granted_nxt    = head32[TREE_W-1:0];
            head_empty_nxt = link_rd_r[LKW-1];
            head_id_nxt    = link_rd_r[TW-1:0];
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        ACT_FREE: begin
          if (tree_ok) begin
            link_we        = 1'b1;
            flag_we        = 1'b1;
            head_empty_nxt = 1'b0;
            head_id_nxt    = tree_addr;
          end
        end
        ACT_ARRIVE: begin
          if (tree_ok) begin
            if (!leaf_ok) begin
              status_nxt = ST_RANGE;
            end else begin
              last_nxt   = !found;
              flag_we    = 1'b1;
              flag_wdata = flags_rd_r | set_mask;
            end
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[wr_addr] <= link_wdata;
    if (flag_we) flag_mem[wr_addr] <= flag_wdata;
    if (cmd.load) begin
      link_rd_r  <= link_mem[head_id_r];
      flags_rd_r <= flag_mem[in_tree_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaves_r     <= LEAVES_RST;
      head_empty_r <= 1'b0;
      head_id_r    <= '0;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_we) leaves_r <= cfg_leaves;
      if (cmd.clr_step && !clr_last) clr_addr_r <= clr_addr_r + TW'(1);
      if (cmd.commit) begin
        head_empty_r <= head_empty_nxt;
        head_id_r    <= head_id_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_action_r <= in_action;
      op_tree_r   <= in_tree_id;
      op_leaf_r   <= in_leaf_index;
    end
    if (cmd.commit) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_granted_tree = granted_r;
  assign out_is_last      = last_r;

endmodule

/* design/arrival_tree_barrier_pool.sv */
// Top level of the arrival tree barrier pool: controller and datapath.
//
// The block keeps NUM_TREES binary arrival trees and a last-in first-out free
// list of their ids. Each request beat on in_ch carries an action (allocate,
// free or arrive), a tree id and a leaf index, and yields exactly one result
// beat on out_ch with a status, the granted tree id and the last-arrival flag.
// The cfg_ch channel writes the leaf count shared by all trees; it is always ready and is
// meant to be written only while no request is in flight.
// In the cycle a request is accepted the link and flag memories are read at
// the free list head and at the named tree. Once the result register is free
// or being drained, the result is formed and registered; an arrival sets the
// nearest clear ancestor flag in the tree's flag word, and a free clears that
// word and links the tree in as the new list head. A new request is taken only
// after the previous one is committed to the result register that drives out_ch.
// After reset the block sweeps both memories to their initial contents (empty
// flags, each link pointing at the next id); in_ch is not ready during that
// sweep, while cfg_ch writes are still taken.
// The result register lets one finished result wait while the next request is
// accepted; if the receiver still stalls, the block holds that request until
// the result register frees up.
module arrival_tree_barrier_pool #(
  parameter int NUM_TREES  = atbp_pkg::DEF_NUM_TREES,
  parameter int MAX_LEAVES = atbp_pkg::DEF_MAX_LEAVES
) (
  input  logic              clk,
  input  logic              rst_n,
  atbp_in_if.sink           in_ch,
  atbp_out_if.source        out_ch,
  atbp_cfg_if.sink          cfg_ch
);
  import atbp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  // Configuration writes land in a plain register and never stall.
  assign cfg_ch.ready = 1'b1;

  atbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .dp_stat   (dp_stat)
  );

  atbp_dp #(
    .NUM_TREES  (NUM_TREES),
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .dp_stat          (dp_stat),
    .in_action        (in_ch.action),
    .in_tree_id       (in_ch.tree_id),
    .in_leaf_index    (in_ch.leaf_index),
    .cfg_we           (cfg_ch.valid && cfg_ch.ready),
    .cfg_leaves       (cfg_ch.leaves_in_use),
    .out_status       (out_ch.status),
    .out_granted_tree (out_ch.granted_tree),
    .out_is_last      (out_ch.is_last)
  );

endmodule

/* design/atbp_checker.sv */
// Port-level checker for the arrival tree barrier pool and its bind statement.
module atbp_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [atbp_pkg::STATUS_W-1:0] out_status,
  input logic [atbp_pkg::TREE_W-1:0]   out_granted_tree,
  input logic                          out_is_last
);
  import atbp_pkg::*;

  // A pending result is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // Requests are worked one at a time: no accept in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one is in flight");

  // A failing request reports neither a tree id nor a completed barrier.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_tree == '0 && !out_is_last)
    else $error("error result carries payload");

  // A completing arrival never also grants a tree.
  a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_status == ST_OK && out_granted_tree == '0)
    else $error("last arrival result carries a granted tree");

endmodule

bind arrival_tree_barrier_pool atbp_port_checker u_atbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_granted_tree (out_ch.granted_tree),
  .out_is_last      (out_ch.is_last)
);
